// ===== rtl/core/skte_pkg.sv =====
`default_nettype none
package skte_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // actions carried by a command beat
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_ADJUST = 3'd2;
    localparam logic [2:0] ACT_PRICE  = 3'd3;
    localparam logic [2:0] ACT_LIST   = 3'd4;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [2:0] STAT_DUPLICATE = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    // per-cell operations
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_ADJUST = 3'd2;
    localparam logic [2:0] CELL_PRICE  = 3'd3;
    localparam logic [2:0] CELL_ROTATE = 3'd4;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] qty;
        logic [23:0]        dollars;
        logic [6:0]         cents;
    } entry_t;

    typedef struct packed {
        logic [2:0]         op;
        logic               cmp_en;
        logic signed [31:0] cmp_key;
        entry_t             data;
        logic [CNT_W-1:0]   count;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/skte_cell.sv =====
`default_nettype none
module skte_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [skte_pkg::IDX_W-1:0]    idx,
    input  wire skte_pkg::cell_ctrl_t          ctrl,
    input  wire skte_pkg::entry_t              prev_entry,
    input  wire logic                          prev_above,
    input  wire skte_pkg::entry_t              next_entry,
    input  wire skte_pkg::entry_t              head_entry,
    output skte_pkg::entry_t                   entry,
    output logic                               above,
    output logic                               match
);
    import skte_pkg::*;

    entry_t           entry_reg;
    entry_t           entry_next;
    logic             above_reg;
    logic             match_reg;
    logic             occupied;
    logic [CNT_W-1:0] my_pos;

    assign my_pos   = CNT_W'(idx);
    assign occupied = my_pos < ctrl.count;

    // compare flags are taken in the same cycle as the command beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            above_reg <= occupied && ($signed(entry_reg.key) > $signed(ctrl.cmp_key));
            match_reg <= occupied && (entry_reg.key == ctrl.cmp_key);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                // larger entries move up one cell, the new one lands at the first gap
                if (prev_above)
                    entry_next = prev_entry;
                else if (above_reg || (my_pos == ctrl.count))
                    entry_next = ctrl.data;
            end
            CELL_ADJUST:
            begin
                if (match_reg)
                    entry_next.qty = entry_reg.qty + ctrl.data.qty;
            end
            CELL_PRICE:
            begin
                if (match_reg)
                begin
                    entry_next.dollars = ctrl.data.dollars;
                    entry_next.cents   = ctrl.data.cents;
                end
            end
            CELL_ROTATE:
            begin
                // occupied cells rotate down, the head entry wraps to the top occupied cell
                if (occupied)
                    entry_next = (my_pos == ctrl.count - CNT_W'(1)) ? head_entry : next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign above = above_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

// ===== rtl/core/skte_select.sv =====
`default_nettype none
module skte_select (
    input  wire skte_pkg::entry_t [skte_pkg::DEPTH-1:0] entries,
    input  wire logic [skte_pkg::DEPTH-1:0]             match,
    output logic                                        hit,
    output skte_pkg::entry_t                            sel
);
    import skte_pkg::*;

    // keys are unique, so at most one match bit is set
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i])
                sel = sel | entries[i];
        end
    end

    assign hit = |match;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_key_table_engine.sv =====
`default_nettype none
// channel  | handshake             | payload
// cmd      | cmd_valid / cmd_stall | action, part_key, quantity_value, price_dollars, price_cents
// res      | res_valid / res_stall | status, entry_key, entry_quantity, entry_dollars,
//          |                       | entry_cents, last_result
//
// insert, search, adjust and set-price run as the beat cycle, where every cell compares its key
// in parallel, then the execute state, which updates the row and loads the result.
// list then goes on in ST_LIST: the row rotates through cell 0 one beat per cycle unless stalled.
// reset clears the entry count and the control state; cell contents need no reset.
// a stalled result holds the execute or list step, and no command is taken until it finishes.
module sorted_key_table_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire logic [2:0]          action,
    input  wire logic signed [31:0]  part_key,
    input  wire logic signed [31:0]  quantity_value,
    input  wire logic [23:0]         price_dollars,
    input  wire logic [6:0]          price_cents,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [2:0]               status,
    output logic signed [31:0]       entry_key,
    output logic signed [31:0]       entry_quantity,
    output logic [23:0]              entry_dollars,
    output logic [6:0]               entry_cents,
    output logic                     last_result
);
    import skte_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             res_valid_reg, res_valid_next;

    logic [2:0]       act_reg;
    entry_t           data_reg;

    logic [2:0]       status_reg, status_next;
    entry_t           res_entry_reg, res_entry_next;
    logic             last_reg, last_next;
    logic             load_res;

    logic             cmd_take;
    logic             res_free;
    logic [2:0]       cell_op;
    cell_ctrl_t       ctrl;

    entry_t [DEPTH-1:0] cell_entry;
    logic [DEPTH-1:0]   cell_above;
    logic [DEPTH-1:0]   cell_match;
    logic               hit;
    entry_t             sel;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid_reg || !res_stall;

    assign ctrl.op      = cell_op;
    assign ctrl.cmp_en  = cmd_take;
    assign ctrl.cmp_key = part_key;
    assign ctrl.data    = data_reg;
    assign ctrl.count   = count_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            skte_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .idx        (IDX_W'(g)),
                .ctrl       (ctrl),
                .prev_entry ((g == 0) ? cell_entry[0] : cell_entry[(g == 0) ? 0 : g - 1]),
                .prev_above ((g == 0) ? 1'b0 : cell_above[(g == 0) ? 0 : g - 1]),
                .next_entry ((g == DEPTH - 1) ? cell_entry[0]
                                              : cell_entry[(g == DEPTH - 1) ? 0 : g + 1]),
                .head_entry (cell_entry[0]),
                .entry      (cell_entry[g]),
                .above      (cell_above[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    skte_select u_select (
        .entries (cell_entry),
        .match   (cell_match),
        .hit     (hit),
        .sel     (sel)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        cell_op        = CELL_HOLD;
        load_res       = 1'b0;
        status_next    = STAT_OK;
        res_entry_next = '0;
        last_next      = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            load_res = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                                status_next = STAT_FULL;
                            else if (hit)
                                status_next = STAT_DUPLICATE;
                            else
                            begin
                                cell_op        = CELL_INSERT;
                                count_next     = count_reg + CNT_W'(1);
                                res_entry_next = data_reg;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            load_res = 1'b1;
                            if (hit)
                                res_entry_next = sel;
                            else
                                status_next = STAT_NOT_FOUND;
                        end
                        ACT_ADJUST:
                        begin
                            load_res = 1'b1;
                            cell_op  = CELL_ADJUST;
                            if (hit)
                            begin
                                res_entry_next     = sel;
                                res_entry_next.qty = sel.qty + data_reg.qty;
                            end
                            else
                                status_next = STAT_NOT_FOUND;
                        end
                        ACT_PRICE:
                        begin
                            load_res = 1'b1;
                            cell_op  = CELL_PRICE;
                            if (hit)
                            begin
                                res_entry_next         = sel;
                                res_entry_next.dollars = data_reg.dollars;
                                res_entry_next.cents   = data_reg.cents;
                            end
                            else
                                status_next = STAT_NOT_FOUND;
                        end
                        ACT_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                load_res    = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                state_next  = ST_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (res_free)
                begin
                    load_res       = 1'b1;
                    cell_op        = CELL_ROTATE;
                    res_entry_next = cell_entry[0];
                    last_next      = (remain_reg == CNT_W'(1));
                    remain_next    = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_res)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            act_reg          <= action;
            data_reg.key     <= part_key;
            data_reg.qty     <= quantity_value;
            data_reg.dollars <= price_dollars;
            data_reg.cents   <= price_cents;
        end
        if (load_res)
        begin
            status_reg    <= status_next;
            res_entry_reg <= res_entry_next;
            last_reg      <= last_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = status_reg;
    assign entry_key      = res_entry_reg.key;
    assign entry_quantity = res_entry_reg.qty;
    assign entry_dollars  = res_entry_reg.dollars;
    assign entry_cents    = res_entry_reg.cents;
    assign last_result    = last_reg;

endmodule
`default_nettype wire
